// ===== rtl/core/bcme_pkg.sv =====
// ----------------------------------------------------------------------------
// bcme_pkg
// shared types, function codes and register indexes of the micro-op executor
// ----------------------------------------------------------------------------
package bcme_pkg;

  // defaults
  localparam int VIOLATION_WIDTH_DEF = 32;
  localparam logic [7:0] ACTIVE_DIM_RESET = 8'd8;

  // fixed field widths
  localparam int FUNC_W       = 3;
  localparam int REG_INDEX_W  = 8;
  localparam int LIMIT_W      = 16;
  localparam int SWITCH_IDX_W = 6;
  localparam int SAMPLE_W     = 32;
  localparam int SWITCH_W     = 64;
  localparam int VIOL_OUT_W   = 32;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROTECT_MASK     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_DIMENSION = 1'd1;

  // micro-op function codes
  localparam logic [FUNC_W-1:0] FN_NOP         = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLAMP_UPPER = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CLAMP_LOWER = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FORCE_ON    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FORCE_OFF   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ASSERT      = 3'd5;

  // one decoded micro-op with its sample
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [REG_INDEX_W-1:0]  reg_index;
    logic signed [LIMIT_W-1:0]  limit;
    logic [SWITCH_IDX_W-1:0] switch_index;
    logic                    hard_flag;
    logic signed [SAMPLE_W-1:0] sample;
    logic                    last_op;
  } op_t;

endpackage

// ===== rtl/core/bcme_op_reg.sv =====
// ----------------------------------------------------------------------------
// bcme_op_reg
// input register: holds one micro-op until the execute stage takes it
// ----------------------------------------------------------------------------
module bcme_op_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bcme_pkg::op_t op_in,
  input  logic          take,
  output logic          op_valid,
  output bcme_pkg::op_t op
);
  import bcme_pkg::*;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !op_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= op_in;
    end
  end

endmodule

// ===== rtl/core/bcme_exec.sv =====
// ----------------------------------------------------------------------------
// bcme_exec
// execute stage: config registers, switchboard, violation mask and result
// ----------------------------------------------------------------------------
module bcme_exec #(
  parameter int VIOLATION_WIDTH = bcme_pkg::VIOLATION_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bcme_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bcme_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  op_valid,
  input  bcme_pkg::op_t                         op,
  output logic                                  take,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bcme_pkg::VIOL_OUT_W-1:0]       violation_bits,
  output logic [bcme_pkg::SWITCH_W-1:0]         switch_state
);
  import bcme_pkg::*;

  localparam int POS_W = $clog2(VIOLATION_WIDTH);

  logic [SWITCH_W-1:0]        protect_mask;
  logic [REG_INDEX_W-1:0]     active_dimension;
  logic [SWITCH_W-1:0]        switchboard, switchboard_next;
  logic [VIOLATION_WIDTH-1:0] violation_acc, violation_acc_next;
  logic [POS_W-1:0]           op_position, op_position_next;

  logic [SWITCH_W-1:0]        sel_bit;
  logic signed [SAMPLE_W-1:0] limit_ext;
  logic                       checked, fail, keep_bit;

  // non-last items need no result slot
  assign take = op_valid && (!op.last_op || !out_valid || out_ready);

  assign sel_bit   = {{(SWITCH_W-1){1'b0}}, 1'b1} << op.switch_index;
  assign limit_ext = SAMPLE_W'(op.limit);
  assign keep_bit  = op.hard_flag && ((protect_mask & sel_bit) != '0);

  always_comb begin
    switchboard_next   = switchboard;
    violation_acc_next = violation_acc;
    checked = 1'b0;
    fail    = 1'b0;
    if (op.reg_index < active_dimension) begin
      unique case (op.func)
        FN_CLAMP_UPPER: begin
          checked = 1'b1;
          fail    = op.sample > limit_ext;
        end
        FN_CLAMP_LOWER: begin
          checked = 1'b1;
          fail    = op.sample < limit_ext;
        end
        FN_FORCE_ON:  switchboard_next = switchboard | sel_bit;
        FN_FORCE_OFF: switchboard_next = switchboard & ~sel_bit;
        FN_ASSERT: begin
          checked = 1'b1;
          fail    = (switchboard & sel_bit) == '0;
        end
        default: ;
      endcase
      if (checked) begin
        if (fail) begin
          violation_acc_next = violation_acc
                             | ({{(VIOLATION_WIDTH-1){1'b0}}, 1'b1} << op_position);
          if (!keep_bit) begin
            switchboard_next = switchboard & ~sel_bit;
          end
        end else begin
          switchboard_next = switchboard | sel_bit;
        end
      end
    end
    if (op_position == POS_W'(VIOLATION_WIDTH - 1)) begin
      op_position_next = '0;
    end else begin
      op_position_next = op_position + 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      protect_mask     <= '0;
      active_dimension <= ACTIVE_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROTECT_MASK:     protect_mask     <= cfg_data;
        CFG_ACTIVE_DIMENSION: active_dimension <= cfg_data[REG_INDEX_W-1:0];
      endcase
    end
  end

  // program state
  always_ff @(posedge clk) begin
    if (rst) begin
      switchboard   <= '0;
      violation_acc <= '0;
      op_position   <= '0;
    end else if (take) begin
      switchboard <= switchboard_next;
      if (op.last_op) begin
        violation_acc <= '0;
        op_position   <= '0;
      end else begin
        violation_acc <= violation_acc_next;
        op_position   <= op_position_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && op.last_op) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && op.last_op) begin
      violation_bits <= VIOL_OUT_W'(violation_acc_next);
      switch_state   <= switchboard_next;
    end
  end

endmodule

// ===== rtl/core/bound_check_microop_executor.sv =====
// ----------------------------------------------------------------------------
// bound_check_microop_executor
// runs bound-check micro-ops against a switchboard and reports per program
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | func reg_index limit switch_index
//           |                      | hard_flag sample last_op
//   out     | out_valid / out_ready| violation_bits switch_state
//   cfg     | cfg_we               | cfg_index cfg_data
//
// one item a cycle sustained; an item is executed while it sits in the input
// register, and a program's result is registered when its last op is taken.
// the execute stage holds the switchboard, so ops retire in order.
// only an item with last_op needs the result register: such an item waits in
// the input register while an earlier result is not yet taken, and only then
// does in_ready drop. synchronous reset clears the switchboard, violation mask,
// op position and the configuration (protect mask 0, dimension 8).
// ----------------------------------------------------------------------------
module bound_check_microop_executor #(
  parameter int VIOLATION_WIDTH = bcme_pkg::VIOLATION_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [bcme_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bcme_pkg::CFG_DATA_W-1:0]      cfg_data,
  // micro-op items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bcme_pkg::FUNC_W-1:0]          func,
  input  logic [bcme_pkg::REG_INDEX_W-1:0]     reg_index,
  input  logic signed [bcme_pkg::LIMIT_W-1:0]  limit,
  input  logic [bcme_pkg::SWITCH_IDX_W-1:0]    switch_index,
  input  logic                                 hard_flag,
  input  logic signed [bcme_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_op,
  // program results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bcme_pkg::VIOL_OUT_W-1:0]      violation_bits,
  output logic [bcme_pkg::SWITCH_W-1:0]        switch_state
);
  import bcme_pkg::*;

  op_t  op_in;   // item as presented on the ports
  op_t  op;      // item held in the input register
  logic op_valid;
  logic take;    // execute stage consumes the held item

  always_comb begin
    op_in.func         = func;
    op_in.reg_index    = reg_index;
    op_in.limit        = limit;
    op_in.switch_index = switch_index;
    op_in.hard_flag    = hard_flag;
    op_in.sample       = sample;
    op_in.last_op      = last_op;
  end

  // input register, frees itself in the cycle its item is taken
  bcme_op_reg u_op_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op_in    (op_in),
    .take     (take),
    .op_valid (op_valid),
    .op       (op)
  );

  // compare, switchboard update and result register
  bcme_exec #(
    .VIOLATION_WIDTH (VIOLATION_WIDTH)
  ) u_exec (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op_valid       (op_valid),
    .op             (op),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .violation_bits (violation_bits),
    .switch_state   (switch_state)
  );

endmodule

// ===== rtl/core/bcme_checker.sv =====
// ----------------------------------------------------------------------------
// bcme_checker
// port-level checks of the micro-op executor, bound to the top level
// ----------------------------------------------------------------------------
module bcme_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bcme_pkg::VIOL_OUT_W-1:0] violation_bits,
  input logic [bcme_pkg::SWITCH_W-1:0]   switch_state
);
  import bcme_pkg::*;

  // a result held back keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(violation_bits)
                                && $stable(switch_state))
    else $error("result changed while stalled");

  // input only stalls behind a blocked result
  a_in_stall: assert property (@(posedge clk)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bound_check_microop_executor bcme_checker u_bcme_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .violation_bits (violation_bits),
  .switch_state   (switch_state)
);
